// ===== hw/rtl/stpr_pkg.sv =====
// ----------------------------------------------------------------------------
// stpr_pkg
// Shared types and constants of the stepper trapezoid profile unit.
// ----------------------------------------------------------------------------
package stpr_pkg;

  localparam int TICK_WIDTH_DEF = 16;

  localparam logic [31:0] ACCEL_SCALED_RST = 32'd65536;
  localparam logic [13:0] ACCEL_STEPS_RST  = 14'd1200;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int IN_DATA_W   = 24;
  localparam int IN_USER_W   = 1;
  localparam int OUT_DATA_W  = 8;

  // register index, from paddr[2]
  localparam logic REG_ACCEL_SCALED = 1'b0;
  localparam logic REG_ACCEL_STEPS  = 1'b1;

  // tuser codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ACCEL  = 4'b0010,
    PH_CRUISE = 4'b0100,
    PH_DECEL  = 4'b1000
  } phase_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EVAL   = 7'b0000010,
    ST_SQUARE = 7'b0000100,
    ST_SCALE  = 7'b0001000,
    ST_RATE   = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_PUT    = 7'b1000000
  } seq_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

// ===== hw/rtl/stpr_mul.sv =====
// ----------------------------------------------------------------------------
// stpr_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module stpr_mul #(
  parameter int MCW = 32,
  parameter int MPW = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [MCW-1:0]         mcand,
  input  logic [MPW-1:0]         mplier,
  output stpr_pkg::unit_st_t     st,
  output logic [MCW+MPW-1:0]     product
);
  import stpr_pkg::*;

  localparam int CNTW = $clog2(MPW + 1);

  logic [MCW-1:0]  hi;
  logic [MPW-1:0]  lo;
  logic [MCW-1:0]  md;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done;
  logic [MCW:0]    sum;

  assign sum     = {1'b0, hi} + (lo[0] ? {1'b0, md} : {(MCW + 1){1'b0}});
  assign product = {hi, lo};
  assign st.busy = busy;
  assign st.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        hi   <= '0;
        lo   <= mplier;
        md   <= mcand;
        cnt  <= CNTW'(MPW);
        busy <= 1'b1;
      end else if (busy) begin
        hi  <= sum[MCW:1];
        lo  <= {sum[0], lo[MPW-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");

endmodule

// ===== hw/rtl/stpr_div.sv =====
// ----------------------------------------------------------------------------
// stpr_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module stpr_div #(
  parameter int NW = 33,
  parameter int DW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NW-1:0]      numer,
  input  logic [DW-1:0]      denom,
  output stpr_pkg::unit_st_t st,
  output logic [NW-1:0]      quot
);
  import stpr_pkg::*;

  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem;
  logic [NW-1:0]   q;
  logic [DW-1:0]   d;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done;
  logic [DW:0]     trial;
  logic [DW+1:0]   diff;
  logic            ge;

  assign trial   = {rem, q[NW-1]};
  assign diff    = {1'b0, trial} - {2'b00, d};
  assign ge      = !diff[DW+1];
  assign quot    = q;
  assign st.busy = busy;
  assign st.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        q    <= numer;
        d    <= denom;
        cnt  <= CNTW'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
        q   <= {q[NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

endmodule

// ===== hw/rtl/stepper_trapezoid_profile_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_trapezoid_profile_unit
// Trapezoidal step ramp generator for one move on one of two axes.
//
//   channel  dir  handshake             contents
//   s_axis   in   tvalid/tready         tuser func, tdata kind + total steps
//   m_axis   out  tvalid/tready         step lines, dir, stepped, busy
//   apb      in   psel/penable/pready   accel_scaled @0, accel_steps @4
//
// Start items, idle ticks and cruise ticks pass from the accept through
// ST_EVAL and ST_PUT to the output register. Accel/decel ticks add two
// serial products (t*t, a*t*t); the accel tick ending the ramp can add one
// more product and a division. Reset is synchronous; no clearing pass. A new
// request is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module stepper_trapezoid_profile_unit #(
  parameter int TICK_WIDTH = stpr_pkg::TICK_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [1:0] step_kind, [17:2] total_steps
  input  logic [stpr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] func
  input  logic [stpr_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] x_step_line, [1] y_step_line, [2] dir_line, [3] stepped, [4] busy_res
  output logic [stpr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stpr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [stpr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [stpr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import stpr_pkg::*;

  localparam int TW  = TICK_WIDTH;
  localparam int SQW = 2 * TW;
  localparam int PW  = SQW + 32;
  localparam int HW  = PW - 33;
  localparam int KW  = (HW > 16) ? HW + 1 : 17;
  localparam int CW  = (TW > 16) ? TW : 16;

  function automatic logic [2:0] step_once(input logic [2:0] lines, input logic [1:0] kind);
    logic [2:0] r;
    r    = lines;
    r[2] = kind[1];
    if (kind[0]) r[1] = !lines[1];
    else         r[0] = !lines[0];
    return r;
  endfunction

  // configuration
  logic [31:0] accel_scaled;
  logic [13:0] accel_steps;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ACCEL_STEPS) ? {18'd0, accel_steps} : accel_scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_scaled <= ACCEL_SCALED_RST;
      accel_steps  <= ACCEL_STEPS_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ACCEL_SCALED: accel_scaled <= pwdata;
        REG_ACCEL_STEPS:  accel_steps  <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  // move state
  seq_t          state;
  phase_t        phase;
  logic [15:0]   done_count;
  logic [TW-1:0] elapsed;
  logic [TW-1:0] ramp_end;
  logic [15:0]   cruise_left;
  logic [15:0]   cruise_interval;
  logic [1:0]    move_kind;
  logic [2:0]    step_lines;
  logic          stepped;

  logic          item_func;
  logic [1:0]    item_kind;
  logic [15:0]   item_total;

  logic          mul_start;
  logic [SQW-1:0] mul_mcand;
  logic [31:0]   mul_mplier;
  logic [PW-1:0] mul_prod;
  unit_st_t      mul_st;

  logic          div_start;
  logic [32:0]   div_numer;
  logic [31:0]   div_denom;
  logic [32:0]   quot;
  unit_st_t      div_st;

  stpr_mul #(.MCW(SQW), .MPW(32)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .mcand(mul_mcand), .mplier(mul_mplier),
    .st(mul_st), .product(mul_prod)
  );

  stpr_div #(.NW(33), .DW(32)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_numer), .denom(div_denom),
    .st(div_st), .quot(quot)
  );

  logic [TW-1:0] elapsed_inc;
  logic [TW-1:0] back_ticks;
  logic [14:0]   twice;
  logic [15:0]   done_inc;
  logic [15:0]   done_dec;
  logic [KW-1:0] pos_k;
  logic [KW-1:0] done_k;
  logic [15:0]   cruise_dec;
  logic          ramp_tick;
  logic          step_up;
  logic          ramp_done;
  logic          need_rate;
  logic          mul_go;
  logic          div_go;
  logic          out_load;

  assign elapsed_inc = (elapsed == {TW{1'b1}}) ? elapsed : elapsed + 1'b1;
  assign back_ticks  = (ramp_end > elapsed_inc) ? ramp_end - elapsed_inc : '0;
  assign twice       = {accel_steps, 1'b0};
  assign done_inc    = done_count + 16'd1;
  assign done_dec    = done_count - 16'd1;
  assign pos_k       = KW'(mul_prod[PW-1:33]);
  assign done_k      = KW'(done_count);
  assign cruise_dec  = (cruise_left != 16'd0) ? cruise_left - 16'd1 : cruise_left;

  assign ramp_tick = (item_func == FUNC_TICK) && (phase == PH_ACCEL || phase == PH_DECEL);
  assign step_up   = (pos_k > done_k);
  assign ramp_done = ((step_up ? done_inc : done_count) > {2'b00, accel_steps});
  assign need_rate = (phase == PH_ACCEL) && ramp_done && (accel_scaled != 32'd0) &&
                     (elapsed != '0);
  assign mul_go    = ((state == ST_EVAL) && ramp_tick) ||
                     ((state == ST_SQUARE) && mul_st.done) ||
                     ((state == ST_SCALE) && mul_st.done && need_rate);
  assign div_go    = (state == ST_RATE) && mul_st.done && !(|mul_prod[PW-1:32]);
  assign out_load  = (state == ST_PUT) && (!m_axis_tvalid || m_axis_tready);

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_start     <= 1'b0;
      div_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      mul_start <= mul_go;
      div_start <= div_go;
      if (out_load)           m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      phase           <= PH_IDLE;
      done_count      <= '0;
      elapsed         <= '0;
      ramp_end        <= '0;
      cruise_left     <= '0;
      cruise_interval <= '0;
      move_kind       <= '0;
      step_lines      <= '0;
      stepped         <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            item_func  <= s_axis_tuser[0];
            item_kind  <= s_axis_tdata[1:0];
            item_total <= s_axis_tdata[17:2];
            stepped    <= 1'b0;
            state      <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state <= ramp_tick ? ST_SQUARE : ST_PUT;
          if (item_func == FUNC_START) begin
            move_kind       <= item_kind;
            cruise_left     <= (item_total >= {1'b0, twice}) ? item_total - {1'b0, twice}
                                                             : 16'd0;
            done_count      <= '0;
            elapsed         <= '0;
            ramp_end        <= '0;
            cruise_interval <= '0;
            phase           <= PH_ACCEL;
          end else begin
            case (phase)
              PH_ACCEL, PH_DECEL: begin
                elapsed    <= elapsed_inc;
                mul_mcand  <= SQW'((phase == PH_ACCEL) ? elapsed_inc : back_ticks);
                mul_mplier <= 32'((phase == PH_ACCEL) ? elapsed_inc : back_ticks);
              end
              PH_CRUISE: begin
                if (CW'(elapsed_inc) >= CW'(cruise_interval)) begin
                  elapsed     <= '0;
                  step_lines  <= step_once(step_lines, move_kind);
                  stepped     <= 1'b1;
                  cruise_left <= cruise_dec;
                  if (cruise_dec == 16'd0) phase <= PH_DECEL;
                end else begin
                  elapsed <= elapsed_inc;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SQUARE: begin
          if (mul_st.done) begin
            mul_mcand  <= mul_prod[SQW-1:0];
            mul_mplier <= accel_scaled;
            state      <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (mul_st.done) begin
            state <= need_rate ? ST_RATE : ST_PUT;
            if (phase == PH_ACCEL) begin
              if (step_up) begin
                done_count <= done_inc;
                step_lines <= step_once(step_lines, move_kind);
                stepped    <= 1'b1;
              end
              if (ramp_done) begin
                ramp_end <= elapsed;
                if (need_rate) begin
                  mul_mcand  <= SQW'(elapsed);
                  mul_mplier <= accel_scaled;
                end else begin
                  cruise_interval <= 16'hFFFF;
                  elapsed         <= '0;
                  phase           <= (cruise_left != 16'd0) ? PH_CRUISE : PH_DECEL;
                end
              end
            end else begin
              if (pos_k < done_k) begin
                done_count <= done_dec;
                step_lines <= step_once(step_lines, move_kind);
                stepped    <= 1'b1;
                if (done_dec == 16'd0) phase <= PH_IDLE;
              end else if (done_count == 16'd0) begin
                phase <= PH_IDLE;
              end
            end
          end
        end
        ST_RATE: begin
          if (mul_st.done) begin
            if (|mul_prod[PW-1:32]) begin
              cruise_interval <= 16'd1;
              elapsed         <= '0;
              phase           <= (cruise_left != 16'd0) ? PH_CRUISE : PH_DECEL;
              state           <= ST_PUT;
            end else begin
              // ceil(2^32 / prod)
              div_numer <= {1'b1, 32'd0} + {1'b0, mul_prod[31:0]} - 33'd1;
              div_denom <= mul_prod[31:0];
              state     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            if (|quot[32:16])             cruise_interval <= 16'hFFFF;
            else if (quot[15:0] == 16'd0) cruise_interval <= 16'd1;
            else                          cruise_interval <= quot[15:0];
            elapsed <= '0;
            phase   <= (cruise_left != 16'd0) ? PH_CRUISE : PH_DECEL;
            state   <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (out_load) begin
            m_axis_tdata <= {3'b000, (phase != PH_IDLE), stepped, step_lines};
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_decel_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DECEL |-> done_count != 16'd0)
    else $error("decel phase with no steps left");

  a_cruise_interval: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CRUISE |-> cruise_interval != 16'd0)
    else $error("cruise phase with zero interval");

  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_st.done |-> (state == ST_SQUARE || state == ST_SCALE || state == ST_RATE))
    else $error("multiplier result with no waiting stage");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == ST_DIV)
    else $error("divider result with no waiting stage");

endmodule

// ===== tb/stepper_trapezoid_profile_unit_tb.sv =====
// ----------------------------------------------------------------------------
// stepper_trapezoid_profile_unit_tb
// Self-checking bench for the trapezoid step ramp generator. A short table of
// directed requests is followed by random moves under changing acceleration
// settings, with random gaps on both stream sides. Every result is compared
// field by field, in request order, with the in-bench predictor or a fixed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stepper_trapezoid_profile_unit_tb;
  import stpr_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_REQS = 1300;
  localparam int PLAN_ROWS   = 24;

  // msb..lsb matches m_axis_tdata[4:0]
  typedef struct packed {
    logic busy_res;
    logic stepped;
    logic dir_line;
    logic y_step_line;
    logic x_step_line;
  } step_res_t;

  localparam step_res_t LEVELS_IDLE = 5'b00000;
  localparam step_res_t LEVELS_BUSY = 5'b10000;

  typedef struct {
    logic        new_cfg;
    logic [31:0] accel;
    logic [13:0] ramp;
    logic        func;
    logic [1:0]  kind;
    logic [15:0] total;
    logic        fixed;
    step_res_t   res;
  } plan_row_t;

  logic                     clk;
  logic                     rst;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_W-1:0]     s_axis_tdata;
  logic [IN_USER_W-1:0]     s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_DATA_W-1:0]    m_axis_tdata;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0]    pwdata;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  stepper_trapezoid_profile_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ramp predictor state
  logic [31:0] cfg_accel;
  logic [13:0] cfg_ramp_steps;
  phase_t      pf_phase;
  logic [15:0] pf_done;
  logic [15:0] pf_elapsed;
  logic [15:0] pf_ramp_end;
  logic [15:0] pf_cruise_left;
  logic [15:0] pf_interval;
  logic [1:0]  pf_kind;
  logic [2:0]  pf_lines;

  step_res_t   expected_levels[$];
  int          mismatch_count;
  int          cycle_count;
  logic        steady;
  int          sink_hold;
  plan_row_t   plan[PLAN_ROWS];

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // (a*t*t) >> 33
  function automatic logic [63:0] ramp_travel(logic [31:0] a, logic [15:0] t);
    return ({32'd0, a} * t * t) >> 33;
  endfunction

  // ceil(2^32 / (a*t)), clamped to 1..65535
  function automatic logic [15:0] cruise_ticks(logic [31:0] a, logic [15:0] t);
    logic [63:0] prod;
    logic [63:0] iv;
    if (a == 0 || t == 0) return 16'hFFFF;
    prod = 64'(a) * 64'(t);
    if (prod >= 64'h1_0000_0000) return 16'd1;
    iv = (64'h1_0000_0000 + prod - 64'd1) / prod;
    if (iv > 64'hFFFF) return 16'hFFFF;
    if (iv == 0) return 16'd1;
    return iv[15:0];
  endfunction

  function automatic plan_row_t plan_row(logic new_cfg, logic [31:0] accel, logic [13:0] ramp,
                                         logic func, logic [1:0] kind, logic [15:0] total,
                                         logic fixed, step_res_t res);
    plan_row_t row;
    row.new_cfg = new_cfg;
    row.accel   = accel;
    row.ramp    = ramp;
    row.func    = func;
    row.kind    = kind;
    row.total   = total;
    row.fixed   = fixed;
    row.res     = res;
    return row;
  endfunction

  task automatic toggle_step_line();
    pf_lines[2] = pf_kind[1];
    if (pf_kind[0]) pf_lines[1] = ~pf_lines[1];
    else pf_lines[0] = ~pf_lines[0];
  endtask

  task automatic advance_profile(input logic func, input logic [1:0] kind,
                                 input logic [15:0] total, output step_res_t res);
    logic        did_step;
    int          twice;
    logic [15:0] u;
    did_step = 1'b0;
    if (func == FUNC_START) begin
      twice          = 2 * int'(cfg_ramp_steps);
      pf_kind        = kind;
      pf_cruise_left = (int'(total) >= twice) ? 16'(int'(total) - twice) : 16'd0;
      pf_done        = '0;
      pf_elapsed     = '0;
      pf_ramp_end    = '0;
      pf_interval    = '0;
      pf_phase       = PH_ACCEL;
    end else if (pf_phase != PH_IDLE) begin
      if (pf_elapsed != 16'hFFFF) pf_elapsed = pf_elapsed + 16'd1;
      case (pf_phase)
        PH_ACCEL: begin
          if (ramp_travel(cfg_accel, pf_elapsed) > 64'(pf_done)) begin
            pf_done = pf_done + 16'd1;
            toggle_step_line();
            did_step = 1'b1;
          end
          if (pf_done > 16'(cfg_ramp_steps)) begin
            pf_ramp_end = pf_elapsed;
            pf_interval = cruise_ticks(cfg_accel, pf_ramp_end);
            pf_elapsed  = '0;
            pf_phase    = (pf_cruise_left != 0) ? PH_CRUISE : PH_DECEL;
          end
        end
        PH_CRUISE: begin
          if (pf_elapsed >= pf_interval) begin
            pf_elapsed = '0;
            toggle_step_line();
            did_step = 1'b1;
            if (pf_cruise_left != 0) pf_cruise_left = pf_cruise_left - 16'd1;
            if (pf_cruise_left == 0) pf_phase = PH_DECEL;
          end
        end
        default: begin
          u = (pf_ramp_end > pf_elapsed) ? pf_ramp_end - pf_elapsed : 16'd0;
          if (ramp_travel(cfg_accel, u) < 64'(pf_done)) begin
            pf_done = pf_done - 16'd1;
            toggle_step_line();
            did_step = 1'b1;
          end
          if (pf_done == 0) pf_phase = PH_IDLE;
        end
      endcase
    end
    res.x_step_line = pf_lines[0];
    res.y_step_line = pf_lines[1];
    res.dir_line    = pf_lines[2];
    res.stepped     = did_step;
    res.busy_res    = (pf_phase != PH_IDLE);
  endtask

  // leaves tvalid high after the accept so a back-to-back request needs no toggle
  task automatic send_req(input logic func, input logic [1:0] kind, input logic [15:0] total,
                          input logic fixed, input step_res_t fixed_res);
    int        gap;
    step_res_t res;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {{(IN_DATA_W-18){1'b0}}, total, kind};
    do @(posedge clk); while (!s_axis_tready);
    advance_profile(func, kind, total, res);
    expected_levels.push_back(fixed ? fixed_res : res);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  // write, then read back in the next transfer
  task automatic cfg_write(input logic idx, input logic [31:0] val);
    logic [31:0] back;
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_ACCEL_SCALED) cfg_accel = val;
    else cfg_ramp_steps = val[13:0];
    want = (idx == REG_ACCEL_SCALED) ? cfg_accel : {18'd0, cfg_ramp_steps};
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (back !== want) begin
      $error("prdata reg %0d: expected %0h, actual %0h", idx, want, back);
      mismatch_count++;
    end
  endtask

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_sink
    step_res_t want;
    step_res_t got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[4:0];
        if (expected_levels.size() == 0) begin
          $error("result with no request pending: %05b", got);
          mismatch_count++;
        end else begin
          want = expected_levels.pop_front();
          check_field("x_step_line", want.x_step_line, got.x_step_line);
          check_field("y_step_line", want.y_step_line, got.y_step_line);
          check_field("dir_line", want.dir_line, got.dir_line);
          check_field("stepped", want.stepped, got.stepped);
          check_field("busy_res", want.busy_res, got.busy_res);
        end
      end
      if (steady) begin
        m_axis_tready <= 1'b1;
      end else if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold <= sink_hold - 1;
      end else begin
        m_axis_tready <= 1'b1;
        sink_hold <= idle_len();
      end
    end
  end

  initial begin : stimulus
    int          counted;
    int          cap;
    int          n;
    int          pick;
    logic [31:0] accel;
    logic [13:0] ramp;
    logic [15:0] total;
    logic        was_idle;
    int          k;

    clk            = 1'b0;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    steady         = 1'b0;
    sink_hold      = 0;
    counted        = 0;

    cfg_accel      = ACCEL_SCALED_RST;
    cfg_ramp_steps = ACCEL_STEPS_RST;
    pf_phase       = PH_IDLE;
    pf_done        = '0;
    pf_elapsed     = '0;
    pf_ramp_end    = '0;
    pf_cruise_left = '0;
    pf_interval    = '0;
    pf_kind        = '0;
    pf_lines       = '0;

    // reset settings: idle tick, start, slow first tick, restart while busy
    plan[0] = plan_row(1'b0, 32'd0, 14'd0, FUNC_TICK, 2'd3, 16'hFFFF, 1'b1, LEVELS_IDLE);
    plan[1] = plan_row(1'b0, 32'd0, 14'd0, FUNC_START, 2'd3, 16'hFFFF, 1'b1, LEVELS_BUSY);
    plan[2] = plan_row(1'b0, 32'd0, 14'd0, FUNC_TICK, 2'd0, 16'h0000, 1'b1, LEVELS_BUSY);
    plan[3] = plan_row(1'b0, 32'd0, 14'd0, FUNC_START, 2'd0, 16'h0000, 1'b1, LEVELS_BUSY);
    // steepest ramp, one ramp step: short move straight into decel
    plan[4] = plan_row(1'b1, 32'hFFFF_FFFF, 14'd1, FUNC_START, 2'd2, 16'd0, 1'b0,
                       LEVELS_IDLE);
    for (int i = 5; i < 10; i++)
      plan[i] = plan_row(1'b0, 32'd0, 14'd0, FUNC_TICK, 2'd0, 16'd0, 1'b0, '0);
    // y axis with cruise at interval 1, then ticks past the end of the move
    plan[10] = plan_row(1'b0, 32'd0, 14'd0, FUNC_START, 2'd1, 16'd6, 1'b0, LEVELS_IDLE);
    for (int i = 11; i < 21; i++)
      plan[i] = plan_row(1'b0, 32'd0, 14'd0, FUNC_TICK, 2'd0, 16'd0, 1'b0, '0);
    // flattest ramp, longest ramp
    plan[21] = plan_row(1'b1, 32'd1, 14'd16383, FUNC_START, 2'd3, 16'hFFFF, 1'b0,
                        LEVELS_IDLE);
    for (int i = 22; i < PLAN_ROWS; i++)
      plan[i] = plan_row(1'b0, 32'd0, 14'd0, FUNC_TICK, 2'd1, 16'd0, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].new_cfg) begin
        wait_idle();
        cfg_write(REG_ACCEL_SCALED, plan[i].accel);
        cfg_write(REG_ACCEL_STEPS, {18'd0, plan[i].ramp});
      end
      send_req(plan[i].func, plan[i].kind, plan[i].total, plan[i].fixed, plan[i].res);
    end

    while (counted < RANDOM_REQS) begin
      wait_idle();
      steady = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        accel = 32'hFFFF_FFFF;
        ramp  = 14'd1;
      end else if (pick == 1) begin
        accel = 32'd1;
        ramp  = 14'd16383;
      end else if (pick == 2) begin
        accel = $urandom;
        ramp  = 14'($urandom_range(1, 16383));
      end else begin
        k     = $urandom_range(26, 31);
        accel = (32'd1 << k) | ($urandom & ((32'd1 << k) - 32'd1));
        ramp  = 14'($urandom_range(1, 6));
      end
      cfg_write(REG_ACCEL_SCALED, accel);
      cfg_write(REG_ACCEL_STEPS, {18'd0, ramp});

      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) total = 16'($urandom_range(0, 40));
        else if (pick == 7) total = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
        else total = 16'($urandom);
        send_req(FUNC_START, 2'($urandom), total, 1'b0, '0);
        counted++;
        cap = $urandom_range(30, 250);
        n = 0;
        while (pf_phase != PH_IDLE && n < cap) begin
          if ($urandom_range(0, 99) == 0)
            send_req(FUNC_START, 2'($urandom), 16'($urandom_range(0, 40)), 1'b0, '0);
          else
            send_req(FUNC_TICK, 2'($urandom), 16'($urandom), 1'b0, '0);
          counted++;
          n++;
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            was_idle = (pf_phase == PH_IDLE);
            send_req(FUNC_TICK, 2'($urandom), 16'($urandom), 1'b0, '0);
            if (!was_idle) counted++;
          end
        end
      end
    end

    steady = 1'b0;
    wait_idle();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/stpr_pkg.sv
hw/rtl/stpr_mul.sv
hw/rtl/stpr_div.sv
hw/rtl/stepper_trapezoid_profile_unit.sv
tb/stepper_trapezoid_profile_unit_tb.sv
